@@ hw/rtl/lld_pkg.sv @@
// ---------------------------------------------------------------------------
// lld_pkg: shared types and constants for the list engine
// Holds the request and status codes and the controller/datapath buses.
// ---------------------------------------------------------------------------
package lld_pkg;
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_INSERT_AT  = 3'd4;
	localparam logic [2:0] REQ_REMOVE_AT  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// memory selector for a read or write
	typedef enum logic [1:0] {
		MEM_FWD,
		MEM_BWD,
		MEM_VAL,
		MEM_FREE
	} mem_sel_t;

	// address source
	typedef enum logic [2:0] {
		ADR_CUR,
		ADR_NEW,
		ADR_PRV,
		ADR_NXT,
		ADR_FTOP,
		ADR_FTOP_M1
	} adr_sel_t;

	typedef struct packed {
		logic     load;       // capture request, first_node into cur
		logic     init;       // sweep free stack, addr from init counter
		logic     rd_en;
		mem_sel_t rd_mem;
		adr_sel_t rd_adr;
		logic     cap_cur;    // cur <= read data
		logic     cap_new;    // new node <= read data
		logic     cap_prv;
		logic     cap_nxt;
		logic     cap_val;
		logic     wr_en;
		mem_sel_t wr_mem;
		adr_sel_t wr_adr;
		logic [1:0] wr_dat;   // 0 new, 1 prv, 2 nxt, 3 cur/value
		logic     ftop_dec;
		logic     ftop_inc;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     set_first;  // first <= first_src
		logic [1:0] first_src; // 0 new, 1 nxt, 2 zero
		logic     set_last;
		logic [1:0] last_src;  // 0 new, 1 prv, 2 zero
		logic     cur_first;  // cur <= first_node
		logic     cur_last;
		logic     clr_removed;
		logic     set_status;
		logic [1:0] status;
		logic     done;
	} lld_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		cnt_t       pos;
		cnt_t       count;
		logic       pool_full;
		logic       cur_is_first;
		logic       cur_is_last;
		logic       init_done;
	} lld_stat_t;
endpackage

@@ hw/rtl/linked_list_deque_engine_unit.sv @@
// ---------------------------------------------------------------------------
// linked_list_deque_engine_unit: circular doubly linked list over a node pool
// Pushes, pops, positional inserts and removes on a 64-node pool.
// ---------------------------------------------------------------------------
// After reset the unit holds busy high while it fills the free stack. A
// transaction is taken at a rising edge where start is high and busy low;
// busy then stays high until the result is out, so only one transaction
// is in flight. Each one answers with a single result on removed_value,
// status and item_count, marked by done for exactly one cycle; the receiver
// cannot stall it, so capture it then. A new transaction may be taken in the
// done cycle. Errors and unused codes go from decode straight to the result.
// Insert and remove at a middle position walk forward links from the first
// node, with a read, a capture and a test per link, since each node memory
// gives one registered read a cycle; the longest walk is 63 links.
module linked_list_deque_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] value,
	input  logic [6:0]  position,
	output logic        done,
	output logic [31:0] removed_value,
	output logic [1:0]  status,
	output logic [6:0]  item_count
);
	import lld_pkg::*;

	lld_cmd_t  cmd;
	lld_stat_t stat;

	// sequencer: decode, walk and step the link updates
	lld_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.done(done), .cmd(cmd), .stat(stat)
	);

	// node pool, pointers and result registers
	lld_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.req_type(req_type), .value(value), .position(position),
		.removed_value(removed_value), .status(status), .item_count(item_count)
	);

`ifndef SYNTHESIS
	// a result never shows while a transaction is in flight
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy);
	// an accepted transaction raises busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy);
	// the count never passes the pool size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_count <= 7'(CAPACITY));
	// result fields are known whenever done marks them
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({removed_value, status, item_count}));
`endif
endmodule

@@ hw/rtl/lld_datapath.sv @@
// ---------------------------------------------------------------------------
// lld_datapath: node pool memories, pointers and result registers
// One read and one write per cycle; read data registered.
// ---------------------------------------------------------------------------
module lld_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lld_pkg::lld_cmd_t cmd,
	output lld_pkg::lld_stat_t stat,
	input  logic [2:0]        req_type,
	input  logic [31:0]       value,
	input  logic [6:0]        position,
	output logic [31:0]       removed_value,
	output logic [1:0]        status,
	output logic [6:0]        item_count
);
	import lld_pkg::*;

	logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
	idx_t fwd_mem [CAPACITY];
	idx_t bwd_mem [CAPACITY];
	idx_t free_mem [CAPACITY];

	logic [2:0] req_q;
	cnt_t pos_q, count_q, ftop_q, init_q;
	logic [DATA_WIDTH-1:0] wval_q, removed_q;
	idx_t first_q, last_q, cur_q, new_q, prv_q, nxt_q;
	logic [1:0] status_q;
	logic [DATA_WIDTH-1:0] rdata_q;

	function automatic idx_t adr(input adr_sel_t s, input idx_t c, input idx_t n,
		input idx_t p, input idx_t x, input cnt_t t);
		case (s)
			ADR_CUR:     return c;
			ADR_NEW:     return n;
			ADR_PRV:     return p;
			ADR_NXT:     return x;
			ADR_FTOP:    return t[IDX_W-1:0];
			ADR_FTOP_M1: return IDX_W'(t - cnt_t'(1));
			default:     return c;
		endcase
	endfunction

	idx_t ra, wa, wd_idx;
	always_comb begin
		ra = adr(cmd.rd_adr, cur_q, new_q, prv_q, nxt_q, ftop_q);
		wa = cmd.init ? init_q[IDX_W-1:0] :
			adr(cmd.wr_adr, cur_q, new_q, prv_q, nxt_q, ftop_q);
		case (cmd.wr_dat)
			2'd0:    wd_idx = new_q;
			2'd1:    wd_idx = prv_q;
			2'd2:    wd_idx = nxt_q;
			default: wd_idx = cur_q;
		endcase
		if (cmd.init)
			wd_idx = IDX_W'(cnt_t'(CAPACITY - 1) - init_q);
	end

	// memories: read registered, one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en || cmd.init) begin
			unique case (cmd.init ? MEM_FREE : cmd.wr_mem)
				MEM_FWD:  fwd_mem[wa]  <= wd_idx;
				MEM_BWD:  bwd_mem[wa]  <= wd_idx;
				MEM_VAL:  val_mem[wa]  <= wval_q;
				MEM_FREE: free_mem[wa] <= wd_idx;
				default: ;
			endcase
		end
		if (cmd.rd_en) begin
			unique case (cmd.rd_mem)
				MEM_FWD:  rdata_q <= DATA_WIDTH'(fwd_mem[ra]);
				MEM_BWD:  rdata_q <= DATA_WIDTH'(bwd_mem[ra]);
				MEM_VAL:  rdata_q <= val_mem[ra];
				MEM_FREE: rdata_q <= DATA_WIDTH'(free_mem[ra]);
				default:  rdata_q <= rdata_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			pos_q  <= position;
			wval_q <= value;
		end
		if (cmd.cap_cur) cur_q <= rdata_q[IDX_W-1:0];
		else if (cmd.cur_first || cmd.load) cur_q <= first_q;
		else if (cmd.cur_last) cur_q <= last_q;
		if (cmd.cap_new) new_q <= rdata_q[IDX_W-1:0];
		if (cmd.cap_prv) prv_q <= rdata_q[IDX_W-1:0];
		if (cmd.cap_nxt) nxt_q <= rdata_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ftop_q    <= cnt_t'(CAPACITY);
			init_q    <= '0;
			first_q   <= '0;
			last_q    <= '0;
			removed_q <= '0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.init) init_q <= init_q + cnt_t'(1);
			if (cmd.ftop_dec) ftop_q <= ftop_q - cnt_t'(1);
			if (cmd.ftop_inc) ftop_q <= ftop_q + cnt_t'(1);
			if (cmd.cnt_inc) count_q <= count_q + cnt_t'(1);
			if (cmd.cnt_dec) count_q <= count_q - cnt_t'(1);
			if (cmd.set_first)
				first_q <= (cmd.first_src == 2'd0) ? new_q :
					(cmd.first_src == 2'd1) ? nxt_q : '0;
			if (cmd.set_last)
				last_q <= (cmd.last_src == 2'd0) ? new_q :
					(cmd.last_src == 2'd1) ? prv_q : '0;
			if (cmd.clr_removed) removed_q <= '0;
			if (cmd.cap_val) removed_q <= rdata_q;
			if (cmd.set_status) status_q <= cmd.status;
		end
	end

	always_comb begin
		stat.req          = req_q;
		stat.pos          = pos_q;
		stat.count        = count_q;
		stat.pool_full    = (ftop_q == '0);
		stat.cur_is_first = (cur_q == first_q);
		stat.cur_is_last  = (cur_q == last_q);
		stat.init_done    = (init_q == cnt_t'(CAPACITY));
	end

	assign removed_value = removed_q;
	assign status        = status_q;
	assign item_count    = count_q;
endmodule

@@ hw/rtl/lld_ctrl.sv @@
// ---------------------------------------------------------------------------
// lld_ctrl: request sequencer
// Decodes a request, walks forward links and steps the link updates.
// ---------------------------------------------------------------------------
module lld_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output lld_pkg::lld_cmd_t  cmd,
	input  lld_pkg::lld_stat_t stat
);
	import lld_pkg::*;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DEC,
		S_I_POP, S_I_NEW, S_I_VAL, S_I_EMPTY1, S_I_EMPTY2, S_I_BWD, S_I_PRV,
		S_I_L1, S_I_L2, S_I_L3, S_I_L4,
		S_WALK, S_WALK_RD, S_WALK_CAP,
		S_R_PRV, S_R_PRVC, S_R_NXTC, S_R_VAL, S_R_VALC, S_R_L1, S_R_L2,
		S_R_FREE, S_FIN
	} state_t;

	state_t state_q;
	logic   insert_q;   // current op inserts
	logic   front_q;    // insert becomes new first
	logic   back_q;     // insert becomes new last
	cnt_t   steps_q;
	logic   done_q;
	logic [1:0] dec_status;

	// outcome of the captured request against the current list
	always_comb begin
		dec_status = ST_OK;
		unique case (stat.req) inside
			REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AT: begin
				if (stat.pool_full)
					dec_status = ST_FULL;
				else if (stat.req == REQ_INSERT_AT && stat.pos > stat.count)
					dec_status = ST_RANGE;
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_AT: begin
				if (stat.count == '0)
					dec_status = ST_EMPTY;
				else if (stat.req == REQ_REMOVE_AT && stat.pos >= stat.count)
					dec_status = ST_RANGE;
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_mem = MEM_FWD; cmd.rd_adr = ADR_CUR;
		cmd.wr_mem = MEM_FWD; cmd.wr_adr = ADR_CUR;
		unique case (state_q)
			S_INIT: cmd.init = !stat.init_done;
			S_IDLE: begin
				cmd.load = start;
				cmd.clr_removed = start;
			end
			S_DEC: begin
				cmd.set_status = 1'b1;
				cmd.status = dec_status;
				cmd.cur_last = (stat.req == REQ_POP_BACK);
			end
			// take a node off the free stack
			S_I_POP: begin
				cmd.rd_en = 1'b1; cmd.rd_mem = MEM_FREE; cmd.rd_adr = ADR_FTOP_M1;
				cmd.ftop_dec = 1'b1;
			end
			S_I_NEW: cmd.cap_new = 1'b1;
			S_I_VAL: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_VAL; cmd.wr_adr = ADR_NEW;
			end
			S_I_EMPTY1: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_FWD; cmd.wr_adr = ADR_NEW; cmd.wr_dat = 2'd0;
				cmd.set_first = 1'b1; cmd.set_last = 1'b1;
			end
			// close the single-node circle backwards
			S_I_EMPTY2: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_BWD; cmd.wr_adr = ADR_NEW; cmd.wr_dat = 2'd0;
			end
			S_I_BWD: begin
				cmd.rd_en = 1'b1; cmd.rd_mem = MEM_BWD; cmd.rd_adr = ADR_CUR;
			end
			S_I_PRV: cmd.cap_prv = 1'b1;
			S_I_L1: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_FWD; cmd.wr_adr = ADR_PRV; cmd.wr_dat = 2'd0;
			end
			S_I_L2: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_BWD; cmd.wr_adr = ADR_NEW; cmd.wr_dat = 2'd1;
			end
			S_I_L3: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_FWD; cmd.wr_adr = ADR_NEW; cmd.wr_dat = 2'd3;
			end
			S_I_L4: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_BWD; cmd.wr_adr = ADR_CUR; cmd.wr_dat = 2'd0;
				cmd.set_first = front_q; cmd.set_last = back_q;
			end
			S_WALK_RD: cmd.rd_en = 1'b1;
			S_WALK_CAP: cmd.cap_cur = 1'b1;
			S_R_PRV: begin
				cmd.rd_en = 1'b1; cmd.rd_mem = MEM_BWD;
			end
			S_R_PRVC: begin
				cmd.cap_prv = 1'b1; cmd.rd_en = 1'b1; cmd.rd_mem = MEM_FWD;
			end
			S_R_NXTC: begin
				cmd.cap_nxt = 1'b1; cmd.rd_en = 1'b1; cmd.rd_mem = MEM_VAL;
			end
			S_R_VALC: begin
				cmd.cap_val = 1'b1;
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_FWD; cmd.wr_adr = ADR_PRV; cmd.wr_dat = 2'd2;
			end
			S_R_L1: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_BWD; cmd.wr_adr = ADR_NXT; cmd.wr_dat = 2'd1;
				if (stat.count == cnt_t'(1)) begin
					cmd.set_first = 1'b1; cmd.first_src = 2'd2;
					cmd.set_last = 1'b1; cmd.last_src = 2'd2;
				end else begin
					cmd.set_first = stat.cur_is_first; cmd.first_src = 2'd1;
					cmd.set_last = stat.cur_is_last; cmd.last_src = 2'd1;
				end
			end
			S_R_FREE: begin
				cmd.wr_en = 1'b1; cmd.wr_mem = MEM_FREE; cmd.wr_adr = ADR_FTOP; cmd.wr_dat = 2'd3;
				cmd.ftop_inc = 1'b1; cmd.cnt_dec = 1'b1;
			end
			default: ;
		endcase
		if (state_q == S_I_EMPTY1 || state_q == S_I_L4) cmd.cnt_inc = 1'b1;
		if (state_q == S_I_EMPTY1) begin
			cmd.wr_dat = 2'd0;
		end
		cmd.done = done_q;
	end

	// hold state and the registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			insert_q <= 1'b0;
			front_q  <= 1'b0;
			back_q   <= 1'b0;
			steps_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: if (stat.init_done) state_q <= S_IDLE;
				S_IDLE: if (start) state_q <= S_DEC;
				S_DEC: begin
					unique case (stat.req) inside
						REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AT: begin
							insert_q <= 1'b1;
							if (stat.pool_full) begin
								state_q <= S_FIN;
							end else if (stat.req == REQ_INSERT_AT &&
								stat.pos > stat.count) begin
								state_q <= S_FIN;
							end else begin
								front_q <= (stat.req == REQ_PUSH_FRONT) ||
									(stat.req == REQ_INSERT_AT && stat.pos == '0);
								back_q <= (stat.req == REQ_PUSH_BACK) ||
									(stat.req == REQ_INSERT_AT && stat.pos == stat.count);
								steps_q <= (stat.req == REQ_INSERT_AT) ? stat.pos : '0;
								state_q <= S_I_POP;
							end
						end
						REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE_AT: begin
							insert_q <= 1'b0;
							if (stat.count == '0 ||
								(stat.req == REQ_REMOVE_AT && stat.pos >= stat.count)) begin
								state_q <= S_FIN;
							end else begin
								steps_q <= (stat.req == REQ_REMOVE_AT) ? stat.pos : '0;
								state_q <= (stat.req == REQ_POP_BACK) ? S_R_PRV : S_WALK;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_I_POP: state_q <= S_I_NEW;
				S_I_NEW: state_q <= S_I_VAL;
				S_I_VAL: state_q <= (stat.count == '0) ? S_I_EMPTY1 :
					(front_q || back_q) ? S_I_BWD : S_WALK;
				S_I_EMPTY1: state_q <= S_I_EMPTY2;
				S_I_EMPTY2: state_q <= S_FIN;
				S_WALK: state_q <= (steps_q == '0) ? (insert_q ? S_I_BWD : S_R_PRV) : S_WALK_RD;
				S_WALK_RD: state_q <= S_WALK_CAP;
				S_WALK_CAP: begin
					steps_q <= steps_q - cnt_t'(1);
					state_q <= S_WALK;
				end
				S_I_BWD: state_q <= S_I_PRV;
				S_I_PRV: state_q <= S_I_L1;
				S_I_L1: state_q <= S_I_L2;
				S_I_L2: state_q <= S_I_L3;
				S_I_L3: state_q <= S_I_L4;
				S_I_L4: state_q <= S_FIN;
				S_R_PRV: state_q <= S_R_PRVC;
				S_R_PRVC: state_q <= S_R_NXTC;
				S_R_NXTC: state_q <= S_R_VAL;
				S_R_VAL: state_q <= S_R_VALC;
				S_R_VALC: state_q <= S_R_L1;
				S_R_L1: state_q <= S_R_L2;
				S_R_L2: state_q <= S_R_FREE;
				S_R_FREE: state_q <= S_FIN;
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
endmodule
